// ----- design/ptbcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptbcs_pkg
// Types and constants shared by the packed three-bit cell store.
// ----------------------------------------------------------------------------
package ptbcs_pkg;

  // Memory geometry
  localparam int MEM_BYTES   = 4096;
  localparam int BANK_DEPTH  = (MEM_BYTES + 1) / 2;
  localparam int BANK_ADDR_W = $clog2(BANK_DEPTH);

  // Field widths
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int CFG_W      = 11;
  localparam int CELL_W     = 3;
  localparam int CELL_IDX_W = ROW_W + CFG_W;      // row*count + column, no overflow
  localparam int BIT_ADDR_W = CELL_IDX_W + 2;     // times three
  localparam int BYTE_IDX_W = BIT_ADDR_W - 3;     // bit address / 8
  localparam int LAST_W     = BYTE_IDX_W + 1;

  // Reset value of the row length register
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = CFG_W'(16);

  // First bit offset at which a cell spills into the next byte
  localparam logic [2:0] OFF_SPLIT = 3'd6;
  localparam logic [2:0] OFF_LAST  = 3'd7;
  localparam logic [2:0] OFF_TOP   = 3'd5;

  // Request kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_RESP
  } ptbcs_state_t;

  typedef struct packed {
    logic              action;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] write_value;
  } ptbcs_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic              out_of_range;
  } ptbcs_out_t;

endpackage

// ----- design/ptbcs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptbcs_ram
// Single-port synchronous RAM, registered read data, read-before-write.
// ----------------------------------------------------------------------------
module ptbcs_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage port
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/packed_three_bit_cell_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_three_bit_cell_store
// Grid of 3-bit cells packed MSB first into a byte memory.
// ----------------------------------------------------------------------------
// A transaction on start/busy reads or writes the cell at (row, column); the
// cell's bit address is (row * column_count + column) * 3. Each transaction
// returns exactly one result, shown for one cycle with out_strobe in the
// response cycle; the receiver cannot stall it. busy drops in that
// response cycle, so the next transaction can be accepted while the last
// one writes back. Each transaction takes these steps: add the column to
// the row product (registered on acceptance) and check the range, then
// the memory read, then the response and write-back. The bytes sit in two banks
// (even and odd byte index) so a cell that straddles two bytes is read and
// written back in a single access. Memory contents are undefined until
// written; there is no clearing pass. column_count may be written only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module packed_three_bit_cell_store
  import ptbcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  ptbcs_in_t        in_data,
  // result channel
  output logic             out_strobe,
  output ptbcs_out_t       out_data,
  // configuration
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ptbcs_state_t state_r, state_nxt;

  logic [CFG_W-1:0]       column_count_r;
  logic                   action_r;
  logic [COL_W-1:0]       column_r;
  logic [CELL_W-1:0]      wval_r;
  logic [CELL_IDX_W-1:0]  prod_r;

  logic [BANK_ADDR_W-1:0] even_addr_r;
  logic [BANK_ADDR_W-1:0] odd_addr_r;
  logic                   odd_first_r;   // first byte lives in odd bank
  logic [2:0]             off_r;
  logic                   oor_r;

  logic                   accept;

  // address stage signals
  logic [CELL_IDX_W-1:0]  cell_idx;
  logic [BIT_ADDR_W-1:0]  bit_addr;
  logic [BYTE_IDX_W-1:0]  byte_idx;
  logic [2:0]             bit_off;
  logic                   split;
  logic [LAST_W-1:0]      last_byte;
  logic [BANK_ADDR_W-1:0] half_idx;

  // memory side
  logic                   ram_en;
  logic [7:0]             even_rdata, odd_rdata;
  logic [7:0]             even_wdata, odd_wdata;
  logic                   even_we, odd_we;
  logic [7:0]             first_b, next_b;
  logic [7:0]             first_new, next_new;
  logic [CELL_W-1:0]      rd_cell;
  logic [2:0]             shamt;
  logic                   we_first, we_next;

  assign accept = start && !busy;

  // Row length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_we) begin
      column_count_r <= cfg_wdata;
    end
  end

  // Capture request, row product computed on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_data.action;
      column_r <= in_data.column;
      wval_r   <= in_data.write_value;
      prod_r   <= CELL_IDX_W'(in_data.row) * CELL_IDX_W'(column_count_r);
    end
  end

  // Address arithmetic: bit address, byte index, offset, range check
  always_comb begin
    cell_idx  = prod_r + CELL_IDX_W'(column_r);
    bit_addr  = BIT_ADDR_W'({cell_idx, 1'b0}) + BIT_ADDR_W'(cell_idx);
    byte_idx  = bit_addr[BIT_ADDR_W-1:3];
    bit_off   = bit_addr[2:0];
    split     = (bit_off >= OFF_SPLIT);
    last_byte = LAST_W'(byte_idx) + LAST_W'(split);
    half_idx  = byte_idx[BANK_ADDR_W:1];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      odd_first_r <= byte_idx[0];
      odd_addr_r  <= half_idx;
      even_addr_r <= byte_idx[0] ? half_idx + BANK_ADDR_W'(1) : half_idx;
      off_r       <= bit_off;
      oor_r       <= (last_byte >= LAST_W'(MEM_BYTES));
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: state_nxt = start ? ST_ADDR : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: outputs
  always_comb begin
    busy       = 1'b1;
    out_strobe = 1'b0;
    ram_en     = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_ADDR: busy = 1'b1;
      ST_READ: ram_en = 1'b1;
      ST_RESP: begin
        busy       = 1'b0;
        out_strobe = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // Byte banks
  ptbcs_ram #(.DEPTH(BANK_DEPTH), .WIDTH(8)) u_even (
    .clk   (clk),
    .en    (ram_en),
    .we    (even_we),
    .addr  (even_addr_r),
    .wdata (even_wdata),
    .rdata (even_rdata)
  );

  ptbcs_ram #(.DEPTH(BANK_DEPTH), .WIDTH(8)) u_odd (
    .clk   (clk),
    .en    (ram_en),
    .we    (odd_we),
    .addr  (odd_addr_r),
    .wdata (odd_wdata),
    .rdata (odd_rdata)
  );

  // Extract and merge the cell bits
  always_comb begin
    first_b   = odd_first_r ? odd_rdata : even_rdata;
    next_b    = odd_first_r ? even_rdata : odd_rdata;
    shamt     = OFF_TOP - off_r;
    first_new = first_b;
    next_new  = next_b;
    rd_cell   = '0;
    case (off_r)
      OFF_SPLIT: begin
        rd_cell   = {first_b[1:0], next_b[7]};
        first_new = {first_b[7:2], wval_r[2:1]};
        next_new  = {wval_r[0], next_b[6:0]};
      end
      OFF_LAST: begin
        rd_cell   = {first_b[0], next_b[7:6]};
        first_new = {first_b[7:1], wval_r[2]};
        next_new  = {wval_r[1:0], next_b[5:0]};
      end
      default: begin
        rd_cell   = CELL_W'(first_b >> shamt);
        first_new = (first_b & ~(8'd7 << shamt)) | (8'(wval_r) << shamt);
      end
    endcase
  end

  // Write-back in the response cycle
  always_comb begin
    we_first   = (state_r == ST_RESP) && (action_r == ACT_WRITE) && !oor_r;
    we_next    = we_first && (off_r >= OFF_SPLIT);
    even_we    = odd_first_r ? we_next : we_first;
    odd_we     = odd_first_r ? we_first : we_next;
    even_wdata = odd_first_r ? next_new : first_new;
    odd_wdata  = odd_first_r ? first_new : next_new;
  end

  // Result
  always_comb begin
    out_data.cell_value   = ((action_r == ACT_READ) && !oor_r) ? rd_cell : '0;
    out_data.out_of_range = oor_r;
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed three-bit cell store.
// ----------------------------------------------------------------------------
// A queue of pending operations (cell requests and row-length writes) is
// filled up front. A falling-edge driver presents requests with random gaps.
// A rising-edge monitor mirrors every accepted transaction into a bit-exact
// shadow of the byte memory and checks each strobed result, in order,
// against the value predicted for it. Reads of in-range cells only ever
// target cells that a previous write has filled.
// ----------------------------------------------------------------------------
module testbench;
  import ptbcs_pkg::*;

  localparam int LAST_CELL    = (MEM_BYTES * 8 - 3) / 3;  // last cell fully in memory
  localparam int MAX_ROW      = (1 << ROW_W) - 1;
  localparam int MAX_COL      = (1 << COL_W) - 1;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  cfg_value;
    ptbcs_in_t         req;
  } pending_op_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  ptbcs_in_t        in_data;
  logic             out_strobe;
  ptbcs_out_t       out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Stimulus side
  pending_op_t  pending_ops[$];
  bit           cell_filled[0:LAST_CELL];
  int           filled_cells[$];
  int           plan_cols;

  // Driver state
  bit           presenting;
  int           gap_left;
  int           burst_left;
  int           issued_count;

  // Prediction and checking state
  bit [7:0]     shadow_bytes[MEM_BYTES];
  int unsigned  grid_cols = 32'(COLUMN_COUNT_RST);
  ptbcs_out_t   expected_cells[$];
  int           taken_count;
  int           mismatch_count;
  int           idle_cycles;

  packed_three_bit_cell_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction: one cell access against the shadow memory
  // --------------------------------------------------------------------------
  function automatic ptbcs_out_t cell_store_access(ptbcs_in_t req);
    int unsigned bit_addr;
    int unsigned byte_idx;
    int unsigned off;
    int unsigned last_byte;
    bit [7:0]    hi_b;
    bit [7:0]    lo_b;
    logic [2:0]  v;
    ptbcs_out_t  res;
    res       = '0;
    bit_addr  = (int'(req.row) * grid_cols + int'(req.column)) * 3;
    byte_idx  = bit_addr >> 3;
    off       = bit_addr & 7;
    last_byte = (off >= 6) ? byte_idx + 1 : byte_idx;
    if (last_byte >= MEM_BYTES) begin
      res.out_of_range = 1'b1;
      return res;
    end
    hi_b = shadow_bytes[byte_idx];
    lo_b = (off >= 6) ? shadow_bytes[byte_idx + 1] : 8'h00;
    v    = req.write_value;
    if (req.action == ACT_READ) begin
      case (off)
        6: begin
          res.cell_value = {hi_b[1:0], lo_b[7]};
        end
        7: begin
          res.cell_value = {hi_b[0], lo_b[7:6]};
        end
        default: begin
          res.cell_value = 3'(hi_b >> (5 - off));
        end
      endcase
    end else begin
      // straddling cells keep the untouched bits of both bytes
      case (off)
        6: begin
          shadow_bytes[byte_idx]     = {hi_b[7:2], v[2:1]};
          shadow_bytes[byte_idx + 1] = {v[0], lo_b[6:0]};
        end
        7: begin
          shadow_bytes[byte_idx]     = {hi_b[7:1], v[2]};
          shadow_bytes[byte_idx + 1] = {v[1:0], lo_b[5:0]};
        end
        default: begin
          shadow_bytes[byte_idx] = (hi_b & ~(8'h07 << (5 - off))) | (8'(v) << (5 - off));
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  function automatic int cell_of(ptbcs_in_t req, int cols);
    return int'(req.row) * cols + int'(req.column);
  endfunction

  function automatic void plan_request(ptbcs_in_t req);
    pending_op_t op;
    int          c;
    c = cell_of(req, plan_cols);
    if (req.action == ACT_WRITE && c <= LAST_CELL && !cell_filled[c]) begin
      cell_filled[c] = 1'b1;
      filled_cells.push_back(c);
    end
    op.is_cfg    = 1'b0;
    op.cfg_value = '0;
    op.req       = req;
    pending_ops.push_back(op);
  endfunction

  function automatic void plan_config(int value);
    pending_op_t op;
    op.is_cfg    = 1'b1;
    op.cfg_value = CFG_W'(value);
    op.req       = '0;
    pending_ops.push_back(op);
    plan_cols = value;
  endfunction

  function automatic ptbcs_in_t make_req(logic act, int r, int col, int val);
    ptbcs_in_t req;
    req.action      = act;
    req.row         = ROW_W'(r);
    req.column      = COL_W'(col);
    req.write_value = CELL_W'(val);
    return req;
  endfunction

  // Find a row/column that lands on cell c; sometimes via a column past row end
  function automatic bit map_cell(int c, int cols, inout ptbcs_in_t req);
    int r;
    int col;
    if (cols == 0) begin
      if (c > MAX_COL) return 1'b0;
      req.row    = ROW_W'($urandom_range(0, MAX_ROW));
      req.column = COL_W'(c);
      return 1'b1;
    end
    r = c / cols;
    if (r > MAX_ROW) r = MAX_ROW;
    col = c - r * cols;
    if (col > MAX_COL) return 1'b0;
    if (r > 0 && col + cols <= MAX_COL && $urandom_range(0, 3) == 0) begin
      r--;
      col += cols;
    end
    req.row    = ROW_W'(r);
    req.column = COL_W'(col);
    return 1'b1;
  endfunction

  // Mostly in-range writes and reads of filled cells, the rest random fields
  function automatic ptbcs_in_t random_request(int cols);
    ptbcs_in_t req;
    int        p;
    int        c;
    int        reach;
    bit        ok;
    req             = '0;
    ok              = 1'b0;
    p               = $urandom_range(0, 99);
    req.write_value = CELL_W'($urandom_range(0, 7));
    reach = (cols == 0) ? MAX_COL : MAX_ROW * cols + MAX_COL;
    if (reach > LAST_CELL) reach = LAST_CELL;
    if (p < 80) begin
      for (int tries = 0; tries < 20 && !ok; tries++) begin
        if (p < 35 && filled_cells.size() > 0) begin
          c          = filled_cells[$urandom_range(0, filled_cells.size() - 1)];
          req.action = ACT_READ;
        end else begin
          c          = $urandom_range(0, reach);
          req.action = ACT_WRITE;
        end
        ok = map_cell(c, cols, req);
      end
    end
    if (!ok) begin
      req.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
      req.row    = ROW_W'($urandom_range(0, MAX_ROW));
      req.column = COL_W'($urandom_range(0, MAX_COL));
      c          = cell_of(req, cols);
      // never read an in-range cell that holds nothing yet
      if (req.action == ACT_READ && c <= LAST_CELL && !cell_filled[c])
        req.action = ACT_WRITE;
    end
    return req;
  endfunction

  function automatic void plan_random(int count);
    for (int i = 0; i < count; i++)
      plan_request(random_request(plan_cols));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents one pending operation at a time on the falling edge
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin : drive_proc
    logic             nxt_start;
    ptbcs_in_t        nxt_data;
    logic             nxt_we;
    logic [CFG_W-1:0] nxt_wdata;
    pending_op_t      head;
    nxt_start = 1'b0;
    nxt_data  = '0;
    nxt_we    = 1'b0;
    nxt_wdata = '0;
    if (rst_n) begin
      nxt_start = start;
      nxt_data  = in_data;
      nxt_wdata = cfg_wdata;
      if (presenting && taken_count == issued_count) presenting = 1'b0;
      if (!presenting) begin
        nxt_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          head = pending_ops[0];
          if (head.is_cfg) begin
            // row length changes only with nothing in flight
            if (expected_cells.size() == 0) begin
              void'(pending_ops.pop_front());
              nxt_we    = 1'b1;
              nxt_wdata = head.cfg_value;
            end
          end else begin
            void'(pending_ops.pop_front());
            nxt_start  = 1'b1;
            nxt_data   = head.req;
            presenting = 1'b1;
            issued_count++;
            if (burst_left > 0) begin
              burst_left--;
              gap_left = 0;
            end else begin
              gap_left = pick_gap();
              if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
            end
          end
        end
      end
    end
    start     <= nxt_start;
    in_data   <= nxt_data;
    cfg_we    <= nxt_we;
    cfg_wdata <= nxt_wdata;
  end

  // --------------------------------------------------------------------------
  // Monitor: checks results, predicts accepted transactions, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_proc
    bit         activity;
    ptbcs_out_t want;
    activity = 1'b0;
    if (rst_n) begin
      if (out_strobe) begin
        activity = 1'b1;
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("unexpected result cell_value=%0d out_of_range=%0b",
                                    out_data.cell_value, out_data.out_of_range));
        end else begin
          want = expected_cells.pop_front();
          if (out_data.cell_value !== want.cell_value)
            report_mismatch($sformatf("cell_value got %0d want %0d",
                                      out_data.cell_value, want.cell_value));
          if (out_data.out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out_of_range got %0b want %0b",
                                      out_data.out_of_range, want.out_of_range));
        end
      end
      if (cfg_we) begin
        grid_cols = 32'(cfg_wdata);
        activity  = 1'b1;
      end
      if (start && !busy) begin
        expected_cells.push_back(cell_store_access(in_data));
        taken_count++;
        activity = 1'b1;
      end
      if (activity) idle_cycles = 0;
      else          idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Reset, stimulus plan and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    plan_cols = int'(COLUMN_COUNT_RST);

    // directed: every bit offset, both straddles, memory edge, grid corner
    for (int k = 0; k < 8; k++) plan_request(make_req(ACT_WRITE, 0, k, 7 - k));
    for (int k = 0; k < 8; k++) plan_request(make_req(ACT_READ, 0, k, k));
    plan_request(make_req(ACT_WRITE, 682, 9, 5));       // last cell inside memory
    plan_request(make_req(ACT_READ, 682, 9, 2));
    plan_request(make_req(ACT_WRITE, 682, 10, 6));      // straddles past the end
    plan_request(make_req(ACT_READ, 682, 10, 1));
    plan_request(make_req(ACT_WRITE, MAX_ROW, MAX_COL, 7));
    plan_request(make_req(ACT_READ, MAX_ROW, MAX_COL, 0));
    plan_request(make_req(ACT_WRITE, 0, 20, 3));        // column past row end
    plan_request(make_req(ACT_READ, 1, 4, 4));          // same cell by row

    plan_random(70);
    plan_config(0);         // every row shares the same cells
    plan_random(60);
    plan_config(1);
    plan_random(70);
    plan_config(1024);
    plan_random(70);
    plan_config((1 << CFG_W) - 1);
    plan_random(60);
    plan_config($urandom_range(2, 1023));
    plan_random(70);
    plan_config(3);
    plan_random(80);
    plan_config($urandom_range(1, 64));
    plan_random(80);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || presenting || expected_cells.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ptbcs_pkg.sv
design/ptbcs_ram.sv
design/packed_three_bit_cell_store.sv
sim/testbench.sv
